// ----- sv/sfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam int HEADER_LEN       = 5;
    localparam int POS_ADDRESS      = 5;
    localparam int POS_TYPE         = 8;
    localparam int FIRST_SAMPLE_POS = 11;

    localparam logic [7:0] SAMPLE_MARKER = 8'h01;

    localparam int SAMPLE_W = 48;

    localparam int DRV_LEFT_BYTE_LO = 2;
    localparam int DRV_LEFT_BYTE_HI = 3;
    localparam int DRV_RIGHT_BYTE   = 0;

    localparam logic [7:0] RESET_LEFT_ADDRESS  = 8'h05;
    localparam logic [7:0] RESET_RIGHT_ADDRESS = 8'h01;

    localparam logic [0:0] CFG_LEFT_ADDRESS  = 1'b0;
    localparam logic [0:0] CFG_RIGHT_ADDRESS = 1'b1;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef struct packed {
        logic                side;
        logic [SAMPLE_W-1:0] sample_bytes;
        logic                left_drive;
        logic                right_drive;
    } sfd_result_t;

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = 8'h7e;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h0e;
            3'd3:    val = 8'h83;
            3'd4:    val = 8'h00;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- sv/sfd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_parser #(
    parameter int RECORD_BYTES = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         in_byte,
    input  wire logic               room,
    input  wire logic [7:0]         left_address,
    input  wire logic [7:0]         right_address,
    output logic                    res_valid,
    output sfd_pkg::sfd_result_t    res
);

    localparam int POS_W  = $clog2(sfd_pkg::FIRST_SAMPLE_POS + RECORD_BYTES + 1);
    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int PACK_W = RECORD_BYTES * 8;
    localparam int WIDE_W = (PACK_W > sfd_pkg::SAMPLE_W) ? PACK_W : sfd_pkg::SAMPLE_W;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       in_byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       addr_reg;
    logic [7:0]       addr_next;
    logic [7:0]       left_reg   [RECORD_BYTES];
    logic [7:0]       left_next  [RECORD_BYTES];
    logic [7:0]       right_reg  [RECORD_BYTES];
    logic [7:0]       right_next [RECORD_BYTES];

    logic             step;
    logic             accept;
    logic [POS_W-1:0] k_full;
    logic [IDX_W-1:0] k;
    logic             side_sel;
    logic [WIDE_W-1:0] wide;
    logic             left_drive;
    logic             right_drive;

    assign step     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign k_full   = pos_reg - POS_W'(sfd_pkg::FIRST_SAMPLE_POS);
    assign k        = k_full[IDX_W-1:0];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (step || !in_valid_reg)
        begin
            in_valid_next = accept;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        right_next = right_reg;
        res_valid  = 1'b0;
        side_sel   = sfd_pkg::SIDE_LEFT;
        if (step)
        begin
            priority if (pos_reg < POS_W'(sfd_pkg::HEADER_LEN))
            begin
                if (in_byte_reg == sfd_pkg::header_byte(pos_reg[2:0]))
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else if (pos_reg == POS_W'(sfd_pkg::POS_ADDRESS))
            begin
                addr_next = in_byte_reg;
                pos_next  = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_W'(sfd_pkg::POS_TYPE))
            begin
                if (in_byte_reg == sfd_pkg::SAMPLE_MARKER)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else if (pos_reg < POS_W'(sfd_pkg::FIRST_SAMPLE_POS))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg < POS_W'(sfd_pkg::FIRST_SAMPLE_POS + RECORD_BYTES))
            begin
                if (addr_reg == left_address || addr_reg == right_address)
                begin
                    side_sel = (addr_reg == left_address) ? sfd_pkg::SIDE_LEFT
                                                          : sfd_pkg::SIDE_RIGHT;
                    for (int i = 0; i < RECORD_BYTES; i++)
                    begin
                        if (k == IDX_W'(i))
                        begin
                            if (side_sel == sfd_pkg::SIDE_LEFT)
                            begin
                                left_next[i] = in_byte_reg;
                            end
                            else
                            begin
                                right_next[i] = in_byte_reg;
                            end
                        end
                    end
                    pos_next  = pos_reg + POS_W'(1);
                    res_valid = (k == IDX_W'(RECORD_BYTES - 1));
                end
                else
                begin
                    pos_next = '0;
                end
            end
            else
            begin
                pos_next = '0;
            end
        end
    end

    always_comb
    begin
        wide = '0;
        for (int i = 0; i < RECORD_BYTES; i++)
        begin
            wide[(RECORD_BYTES - 1 - i) * 8 +: 8] =
                (side_sel == sfd_pkg::SIDE_RIGHT) ? right_next[i] : left_next[i];
        end
    end

    generate
        if (RECORD_BYTES > sfd_pkg::DRV_LEFT_BYTE_HI)
        begin : g_left_two
            assign left_drive = (left_next[sfd_pkg::DRV_LEFT_BYTE_LO] != 8'h00)
                             || (left_next[sfd_pkg::DRV_LEFT_BYTE_HI] != 8'h00);
        end
        else if (RECORD_BYTES > sfd_pkg::DRV_LEFT_BYTE_LO)
        begin : g_left_one
            assign left_drive = (left_next[sfd_pkg::DRV_LEFT_BYTE_LO] != 8'h00);
        end
        else
        begin : g_left_none
            assign left_drive = 1'b0;
        end
    endgenerate

    assign right_drive = (right_next[sfd_pkg::DRV_RIGHT_BYTE] != 8'h00);

    assign res.side         = side_sel;
    assign res.sample_bytes = wide[sfd_pkg::SAMPLE_W-1:0];
    assign res.left_drive   = left_drive;
    assign res.right_drive  = right_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
            addr_reg     <= '0;
            for (int i = 0; i < RECORD_BYTES; i++)
            begin
                left_reg[i]  <= '0;
                right_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            addr_reg     <= addr_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sfd_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire sfd_pkg::sfd_result_t push_data,
    output logic                      room,
    output logic                      pop_valid,
    input  wire logic                 pop_stall,
    output sfd_pkg::sfd_result_t      pop_data
);

    sfd_pkg::sfd_result_t ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign room      = (count_reg != 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_data  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sensor_frame_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// rx        in         rx_valid / rx_stall  rx_byte
// out       out        out_valid / out_stall side, sample_bytes, left_drive, right_drive
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One received byte is taken every clock cycle while rx_stall is low.
// A byte is registered on its beat and parsed once the result queue has room, and
// a frame's result beat is offered in the cycle after its last sample byte is parsed.
// Results wait in a two-entry queue; rx_stall is raised only while that queue is
// full and a byte is already waiting to be parsed.
// Reset clears the parse position, the address and both sample records.

module sensor_frame_deframer #(
    parameter int RECORD_BYTES = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rx_valid,
    output logic                               rx_stall,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               side,
    output logic [sfd_pkg::SAMPLE_W-1:0]       sample_bytes,
    output logic                               left_drive,
    output logic                               right_drive,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [7:0]                    cfg_data
);

    logic [7:0]           left_address_reg;
    logic [7:0]           left_address_next;
    logic [7:0]           right_address_reg;
    logic [7:0]           right_address_next;
    logic                 room;
    logic                 res_valid;
    sfd_pkg::sfd_result_t res;
    sfd_pkg::sfd_result_t out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        left_address_next  = left_address_reg;
        right_address_next = right_address_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_LEFT_ADDRESS:  left_address_next  = cfg_data;
                sfd_pkg::CFG_RIGHT_ADDRESS: right_address_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_address_reg  <= sfd_pkg::RESET_LEFT_ADDRESS;
            right_address_reg <= sfd_pkg::RESET_RIGHT_ADDRESS;
        end
        else
        begin
            left_address_reg  <= left_address_next;
            right_address_reg <= right_address_next;
        end
    end

    sfd_parser #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (rx_valid),
        .in_stall      (rx_stall),
        .in_byte       (rx_byte),
        .room          (room),
        .left_address  (left_address_reg),
        .right_address (right_address_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    sfd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .pop_data  (out_res)
    );

    assign side         = out_res.side;
    assign sample_bytes = out_res.sample_bytes;
    assign left_drive   = out_res.left_drive;
    assign right_drive  = out_res.right_drive;

endmodule

`default_nettype wire

// ----- sv/sfd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfd_checker #(
    parameter int RECORD_BYTES = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    rx_stall,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic                    side,
    input  wire logic [sfd_pkg::SAMPLE_W-1:0] sample_bytes,
    input  wire logic                    left_drive,
    input  wire logic                    right_drive
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its side and sample bytes.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_bytes) && $stable(side))
        else $error("result payload changed while stalled");

    // The input side only stalls when results are backed up.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> out_valid)
        else $error("rx stalled with no pending result");

    generate
        if (RECORD_BYTES >= 1 && RECORD_BYTES * 8 <= sfd_pkg::SAMPLE_W)
        begin : g_right_flag
            a_right_drive: assert property (@(posedge clk) disable iff (!rst_n)
                out_valid && side == sfd_pkg::SIDE_RIGHT |->
                    right_drive == (sample_bytes[RECORD_BYTES*8-1 -: 8] != 8'h00))
                else $error("right drive flag disagrees with right record");
        end
        if (RECORD_BYTES >= 4 && RECORD_BYTES * 8 <= sfd_pkg::SAMPLE_W)
        begin : g_left_flag
            a_left_drive: assert property (@(posedge clk) disable iff (!rst_n)
                out_valid && side == sfd_pkg::SIDE_LEFT |->
                    left_drive == ((sample_bytes[(RECORD_BYTES-2)*8-1 -: 8] != 8'h00)
                                || (sample_bytes[(RECORD_BYTES-3)*8-1 -: 8] != 8'h00)))
                else $error("left drive flag disagrees with left record");
        end
    endgenerate

endmodule

bind sensor_frame_deframer sfd_checker #(
    .RECORD_BYTES(RECORD_BYTES)
) u_sfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_stall     (rx_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .side         (side),
    .sample_bytes (sample_bytes),
    .left_drive   (left_drive),
    .right_drive  (right_drive)
);

`default_nettype wire
